// ===== src/bpfa_pkg.sv =====
package bpfa_pkg;

	// Sizing of the managed page space
	localparam int MAX_PAGES     = 8192;
	localparam int PAGE_BYTES    = 4096;
	localparam int WORD_BITS     = 64;
	localparam int WORD_COUNT    = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int OFFSET_BITS   = $clog2(PAGE_BYTES);
	localparam int PAGE_BITS     = $clog2(MAX_PAGES);
	localparam int BIT_IDX_BITS  = $clog2(WORD_BITS);
	localparam int WORD_IDX_BITS = $clog2(WORD_COUNT);
	localparam int SCAN_BITS     = WORD_IDX_BITS + 1;

	// Field widths
	localparam int ADDR_W   = 25;
	localparam int COUNT_W  = 14;
	localparam int STATUS_W = 2;

	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(6144);
	localparam logic [COUNT_W-1:0] MANAGED_MAX     = COUNT_W'(MAX_PAGES);
	localparam logic [COUNT_W-1:0] COUNT_SAT       = {COUNT_W{1'b1}};
	localparam logic [WORD_BITS-1:0] ALL_USED      = {WORD_BITS{1'b1}};

	// Operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_PAGE = 2'd1,
		ST_NULL    = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FREE_WR,
		S_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic latch_in;
		logic start_scan;
		logic scan;
		logic commit;
		logic free_wr;
		logic set_fail;
		logic set_null;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic func;
		logic addr_zero;
		logic no_room;
		logic hit;
		logic exhausted;
		logic out_free;
	} sts_t;

endpackage

// ===== src/bpfa_ctrl.sv =====
module bpfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bpfa_pkg::sts_t sts,
	output bpfa_pkg::cmd_t cmd
);
	import bpfa_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.func == FUNC_ALLOC) begin
					if (sts.no_room) begin
						cmd.set_fail = 1'b1;
						state_d      = S_EMIT;
					end else begin
						cmd.start_scan = 1'b1;
						state_d        = S_SCAN;
					end
				end else if (sts.addr_zero) begin
					cmd.set_null = 1'b1;
					state_d      = S_EMIT;
				end else begin
					// word read is issued this cycle
					state_d = S_FREE_WR;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.commit = 1'b1;
					state_d    = S_EMIT;
				end else if (sts.exhausted) begin
					cmd.set_fail = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_FREE_WR: begin
				cmd.free_wr = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/bpfa_dp.sv =====
module bpfa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpfa_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          func,
	input  logic [bpfa_pkg::ADDR_W-1:0]   free_address,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bpfa_pkg::STATUS_W-1:0] status,
	output logic [bpfa_pkg::ADDR_W-1:0]   page_address,
	output logic [bpfa_pkg::COUNT_W-1:0]  used_count,
	output logic [bpfa_pkg::COUNT_W-1:0]  free_count,
	input  bpfa_pkg::cmd_t                cmd,
	output bpfa_pkg::sts_t                sts
);
	import bpfa_pkg::*;

	// Bitmap store and per-word valid bits (invalid word reads as all free)
	logic [WORD_BITS-1:0]  mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] wvalid_q;

	logic [COUNT_W-1:0]       block_count_q;
	logic [COUNT_W-1:0]       used_q;
	logic                     func_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [SCAN_BITS-1:0]     rd_idx_q;
	logic [SCAN_BITS-1:0]     chk_idx_s1;
	logic                     chk_live_s1;
	logic [WORD_BITS-1:0]     rd_data_s1;
	logic                     rd_vld_s1;
	status_t                  res_status_q;
	logic [ADDR_W-1:0]        res_page_q;
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [ADDR_W-1:0]        out_page_q;
	logic [COUNT_W-1:0]       out_used_q;
	logic [COUNT_W-1:0]       out_free_q;

	logic [COUNT_W-1:0]       managed;
	logic [SCAN_BITS-1:0]     words;
	logic [COUNT_W-1:0]       pages_free;
	logic [WORD_IDX_BITS-1:0] rd_addr;
	logic [WORD_IDX_BITS-1:0] free_word;
	logic [BIT_IDX_BITS-1:0]  free_bit;
	logic [WORD_BITS-1:0]     cur_word;
	logic [WORD_BITS-1:0]     low_zero;
	logic [BIT_IDX_BITS-1:0]  hit_bit;
	logic [PAGE_BITS-1:0]     hit_page;
	logic                     mem_we;
	logic [WORD_IDX_BITS-1:0] wr_addr;
	logic [WORD_BITS-1:0]     wr_data;

	// Page counts
	assign managed    = (block_count_q > MANAGED_MAX) ? MANAGED_MAX : block_count_q;
	assign words      = managed[COUNT_W-1:BIT_IDX_BITS];
	assign pages_free = (used_q >= managed) ? '0 : managed - used_q;

	// Word and bit of the page being freed
	assign free_word = addr_q[OFFSET_BITS+BIT_IDX_BITS +: WORD_IDX_BITS];
	assign free_bit  = addr_q[OFFSET_BITS +: BIT_IDX_BITS];

	// Read address: scan counter while scanning, else the free target
	assign rd_addr = cmd.scan ? rd_idx_q[WORD_IDX_BITS-1:0] : free_word;

	// Word under check and its lowest clear bit
	assign cur_word = rd_vld_s1 ? rd_data_s1 : '0;
	assign low_zero = ~cur_word & (cur_word + WORD_BITS'(1));

	always_comb begin
		hit_bit = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (low_zero[b]) begin
				hit_bit = hit_bit | BIT_IDX_BITS'(b);
			end
		end
	end

	assign hit_page = {chk_idx_s1[WORD_IDX_BITS-1:0], hit_bit};

	// Bitmap write port
	always_comb begin
		mem_we  = cmd.commit | cmd.free_wr;
		wr_addr = cmd.commit ? chk_idx_s1[WORD_IDX_BITS-1:0] : free_word;
		wr_data = cmd.commit ? (cur_word | low_zero)
		                     : (cur_word & ~(WORD_BITS'(1) << free_bit));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				wvalid_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= wvalid_q[rd_addr];
		end
	end

	// Configuration and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			used_q        <= '0;
		end else begin
			if (cfg_we) begin
				block_count_q <= cfg_data;
			end
			if (cmd.commit && used_q != COUNT_SAT) begin
				used_q <= used_q + COUNT_W'(1);
			end else if (cmd.free_wr && used_q != '0) begin
				used_q <= used_q - COUNT_W'(1);
			end
		end
	end

	// Scan pipeline: read stage then check stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			chk_idx_s1  <= '0;
			chk_live_s1 <= 1'b0;
		end else begin
			if (cmd.start_scan) begin
				rd_idx_q <= '0;
			end else if (cmd.scan) begin
				rd_idx_q <= rd_idx_q + SCAN_BITS'(1);
			end
			chk_idx_s1  <= rd_idx_q;
			chk_live_s1 <= cmd.scan && !cmd.commit && !cmd.set_fail && (rd_idx_q < words);
		end
	end

	// Latched transaction and pending result
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q <= func;
			addr_q <= free_address;
		end
		if (cmd.set_fail) begin
			res_status_q <= ST_NO_PAGE;
			res_page_q   <= '0;
		end else if (cmd.set_null) begin
			res_status_q <= ST_NULL;
			res_page_q   <= '0;
		end else if (cmd.commit) begin
			res_status_q <= ST_OK;
			res_page_q   <= {hit_page, {OFFSET_BITS{1'b0}}};
		end else if (cmd.free_wr) begin
			res_status_q <= ST_OK;
			res_page_q   <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_page_q   <= res_page_q;
			out_used_q   <= used_q;
			out_free_q   <= pages_free;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign page_address = out_page_q;
	assign used_count   = out_used_q;
	assign free_count   = out_free_q;

	// Status to controller
	always_comb begin
		sts.func      = func_q;
		sts.addr_zero = (addr_q == '0);
		sts.no_room   = (pages_free == '0) || (words == '0);
		sts.hit       = chk_live_s1 && (cur_word != ALL_USED);
		sts.exhausted = chk_live_s1 && (chk_idx_s1 == words - SCAN_BITS'(1));
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

// ===== src/bitmap_page_frame_allocator.sv =====
// Channel  Handshake               Payload
// config   cfg_we                  cfg_data (block_count)
// input    in_valid / in_ready     func, free_address
// output   out_valid / out_ready   status, page_address, used_count, free_count
//
// An allocate passes through decode, then scans the bitmap words in order, up to 128 of them,
// read one word per cycle from the read port of the bitmap memory, and then emits its result.
// A free reads the word, writes it back and emits; a null free or an allocate with no free page emits from decode.
// The controller returns to idle after each result before the next transaction is taken.
// Reset clears the bitmap at once through per-word valid bits and the used count.
// One transaction is in work at a time; a new one is taken while a result still waits.
module bitmap_page_frame_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpfa_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [bpfa_pkg::ADDR_W-1:0]   free_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bpfa_pkg::STATUS_W-1:0] status,
	output logic [bpfa_pkg::ADDR_W-1:0]   page_address,
	output logic [bpfa_pkg::COUNT_W-1:0]  used_count,
	output logic [bpfa_pkg::COUNT_W-1:0]  free_count
);
	import bpfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bpfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpfa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.func         (func),
		.free_address (free_address),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.page_address (page_address),
		.used_count   (used_count),
		.free_count   (free_count),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ===== tb/tb_bitmap_page_frame_allocator.sv =====
module tb_bitmap_page_frame_allocator;
	import bpfa_pkg::*;

	// One predicted result transaction
	typedef struct {
		status_t              status;
		logic [ADDR_W-1:0]    page_address;
		logic [COUNT_W-1:0]   used_count;
		logic [COUNT_W-1:0]   free_count;
	} page_result_t;

	localparam int RANDOM_ITEMS = 1700;
	localparam int MAX_IDLE     = 17;
	localparam int TAIL_CYCLES  = 140;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [COUNT_W-1:0]  cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = FUNC_ALLOC;
	logic [ADDR_W-1:0]   free_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   page_address;
	logic [COUNT_W-1:0]  used_count;
	logic [COUNT_W-1:0]  free_count;

	bitmap_page_frame_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.free_address (free_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.page_address (page_address),
		.used_count   (used_count),
		.free_count   (free_count)
	);

	// Shadow copy of the allocator state
	logic [WORD_BITS-1:0] used_map [WORD_COUNT];
	logic [COUNT_W-1:0]   used_pages_m;
	logic [COUNT_W-1:0]   block_count_m;

	page_result_t page_result_q[$];
	int           alloc_pages_q[$];
	page_result_t head_result;
	int           mismatch_count = 0;
	bit           quiet_mode = 1'b0;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#40000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int managed_pages();
		return (block_count_m > MANAGED_MAX) ? MAX_PAGES : int'(block_count_m);
	endfunction

	function automatic int pages_left();
		int m;
		m = managed_pages();
		return (int'(used_pages_m) >= m) ? 0 : m - int'(used_pages_m);
	endfunction

	task automatic log_mismatch(input string msg);
		if (mismatch_count < 10)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// First-fit allocate or free on the shadow bitmap; queues the expected result
	task automatic compute_page_op(input logic op, input logic [ADDR_W-1:0] addr);
		page_result_t r;
		int           words;
		int           page;
		bit           found;
		r.status       = ST_OK;
		r.page_address = '0;
		found          = 1'b0;
		page           = 0;
		if (op == FUNC_ALLOC) begin
			if (pages_left() != 0) begin
				words = managed_pages() / WORD_BITS;
				for (int w = 0; w < words && !found; w++) begin
					if (used_map[w] != ALL_USED) begin
						for (int b = 0; b < WORD_BITS && !found; b++) begin
							if (!used_map[w][b]) begin
								page           = w * WORD_BITS + b;
								used_map[w][b] = 1'b1;
								found          = 1'b1;
							end
						end
					end
				end
			end
			if (found) begin
				if (used_pages_m != COUNT_SAT)
					used_pages_m++;
				r.page_address = ADDR_W'(page * PAGE_BYTES);
				alloc_pages_q.push_back(page);
			end else begin
				r.status = ST_NO_PAGE;
			end
		end else if (addr == '0) begin
			r.status = ST_NULL;
		end else begin
			page = int'(addr) / PAGE_BYTES;
			if (page < MAX_PAGES)
				used_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
			if (used_pages_m != '0)
				used_pages_m--;
		end
		r.used_count = used_pages_m;
		r.free_count = COUNT_W'(pages_left());
		page_result_q.push_back(r);
	endtask

	// Send one request transaction; valid stays up until accepted
	task automatic send_page_op(input logic op, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= op;
		free_address <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		compute_page_op(op, addr);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (page_result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic set_block_count(input logic [COUNT_W-1:0] value);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		block_count_m  = value;
	endtask

	task automatic test_alloc_free_basics();
		send_page_op(FUNC_ALLOC, ADDR_W'($urandom));
		send_page_op(FUNC_ALLOC, '0);
		send_page_op(FUNC_ALLOC, '1);
		// null free
		send_page_op(FUNC_FREE, '0);
		// unaligned free, then the same page again while already free
		send_page_op(FUNC_FREE, ADDR_W'(PAGE_BYTES + 'h123));
		send_page_op(FUNC_FREE, ADDR_W'(PAGE_BYTES));
		send_page_op(FUNC_ALLOC, '0);
		// top address, page never allocated
		send_page_op(FUNC_FREE, '1);
		// page zero can only be freed through a nonzero offset
		send_page_op(FUNC_FREE, ADDR_W'(PAGE_BYTES - 1));
		send_page_op(FUNC_ALLOC, '0);
	endtask

	task automatic test_pool_limits();
		// empty pool: nothing usable
		set_block_count('0);
		send_page_op(FUNC_ALLOC, '0);
		send_page_op(FUNC_FREE, '0);
		// pool under one word: free pages counted but no word searched
		set_block_count(COUNT_W'(WORD_BITS - 1));
		send_page_op(FUNC_ALLOC, '0);
		// register above the page space
		set_block_count(COUNT_SAT);
		send_page_op(FUNC_ALLOC, '0);
		send_page_op(FUNC_ALLOC, '0);
		set_block_count(MANAGED_MAX);
		send_page_op(FUNC_ALLOC, '0);
		// trailing partial word
		set_block_count(COUNT_W'(100));
		send_page_op(FUNC_ALLOC, '0);
		set_block_count(COUNT_W'(WORD_BITS));
		send_page_op(FUNC_ALLOC, '0);
	endtask

	task automatic test_used_count_floor();
		set_block_count(BLOCK_COUNT_RST);
		while (used_pages_m != '0)
			send_page_op(FUNC_FREE, ADDR_W'(8000 * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)));
		// one more free with the count already at zero
		send_page_op(FUNC_FREE, ADDR_W'(8000 * PAGE_BYTES));
	endtask

	task automatic test_random_phases();
		int                sent;
		int                phase_len;
		int                alloc_pct;
		int                sel;
		int                idx;
		int                page;
		logic [ADDR_W-1:0] addr;
		logic [COUNT_W-1:0] bc;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       bc = '0;
				1:       bc = COUNT_W'(WORD_BITS - 1);
				2:       bc = COUNT_W'(WORD_BITS);
				3:       bc = COUNT_W'(WORD_BITS + 1);
				4:       bc = MANAGED_MAX;
				5:       bc = COUNT_SAT;
				6:       bc = COUNT_W'($urandom_range(MAX_PAGES + 1, 16383));
				7, 8:    bc = COUNT_W'($urandom_range(WORD_BITS, 5 * WORD_BITS));
				default: bc = COUNT_W'($urandom_range(0, MAX_PAGES));
			endcase
			set_block_count(bc);
			quiet_mode = ($urandom_range(0, 4) == 0);
			phase_len  = $urandom_range(20, 100);
			case ($urandom_range(0, 3))
				0:       alloc_pct = 20;
				1:       alloc_pct = 50;
				default: alloc_pct = 85;
			endcase
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					send_page_op(FUNC_ALLOC, ADDR_W'($urandom));
				end else begin
					sel = $urandom_range(0, 99);
					if (sel < 55 && alloc_pages_q.size() > 0) begin
						// release a page handed out earlier
						idx  = $urandom_range(0, alloc_pages_q.size() - 1);
						page = alloc_pages_q[idx];
						alloc_pages_q.delete(idx);
						addr = ADDR_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
					end else if (sel < 70) begin
						addr = ADDR_W'($urandom);
					end else if (sel < 80) begin
						addr = '0;
					end else begin
						page = $urandom_range(0, (managed_pages() > 0) ? managed_pages() - 1 : 0);
						addr = ADDR_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
					end
					send_page_op(FUNC_FREE, addr);
				end
				sent++;
			end
		end
		quiet_mode = 1'b0;
		drain_results();
	endtask

	// Receiver: random stall before each result transaction
	initial begin
		int gap;
		forever begin
			gap = quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (page_result_q.size() == 0) begin
				log_mismatch($sformatf("unexpected result status=%0d addr=%h used=%0d free=%0d",
					status, page_address, used_count, free_count));
			end else begin
				head_result = page_result_q.pop_front();
				if (status !== head_result.status || page_address !== head_result.page_address ||
					used_count !== head_result.used_count ||
					free_count !== head_result.free_count) begin
					log_mismatch($sformatf(
						"exp status=%0d addr=%h used=%0d free=%0d, got status=%0d addr=%h used=%0d free=%0d",
						head_result.status, head_result.page_address, head_result.used_count,
						head_result.free_count, status, page_address, used_count, free_count));
				end
			end
		end
	end

	// Test sequence
	initial begin
		for (int w = 0; w < WORD_COUNT; w++)
			used_map[w] = '0;
		used_pages_m  = '0;
		block_count_m = BLOCK_COUNT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alloc_free_basics();
		test_pool_limits();
		test_used_count_floor();
		test_random_phases();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (page_result_q.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", page_result_q.size()));
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== bitmap_page_frame_allocator.f =====
src/bpfa_pkg.sv
src/bpfa_ctrl.sv
src/bpfa_dp.sv
src/bitmap_page_frame_allocator.sv
tb/tb_bitmap_page_frame_allocator.sv
